[rtl/bfsam_pkg.sv]
// shared types and constants for the breadth-first search block
// no dependencies

package bfsam_pkg;

  localparam int VERTEX_W = 4;
  localparam int EDGE_W = 16;
  localparam int COUNT_W = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_VERTEX = 2'd1;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;
  localparam logic [VERTEX_W-1:0] START_VERTEX_RESET = 4'd0;

  typedef struct packed {
    logic row_write;
    logic init;
    logic fetch;
    logic read_row;
    logic scan;
    logic enqueue;
    logic load_result;
    logic load_bad;
  } bfsam_cmd_t;

  typedef struct packed {
    logic bad_start;
    logic pending_empty;
    logic last_result;
  } bfsam_status_t;

endpackage

[rtl/bfsam_if.sv]
// item channels for adjacency rows in and visited vertices out
// depends on bfsam_pkg

interface bfsam_row_if
  import bfsam_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] row_index;
  logic [EDGE_W-1:0]   row_edges;
  logic                last_row;

  modport source (output valid, row_index, row_edges, last_row, input ready);
  modport sink (input valid, row_index, row_edges, last_row, output ready);
endinterface

interface bfsam_result_if
  import bfsam_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex;
  logic                run_end;
  logic                bad_start;

  modport source (output valid, vertex, run_end, bad_start, input ready);
  modport sink (input valid, vertex, run_end, bad_start, output ready);
endinterface

[rtl/bfsam_datapath.sv]
// datapath: config registers, adjacency row memory, vertex fifo, visited mask
// depends on bfsam_pkg

module bfsam_datapath
  import bfsam_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bfsam_cmd_t             cmd,
  output bfsam_status_t          status,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [VERTEX_W-1:0]    row_index,
  input  logic [EDGE_W-1:0]      row_edges,
  output logic [VERTEX_W-1:0]    vertex,
  output logic                   run_end,
  output logic                   bad_start
);

  localparam int ROW_DEPTH = (MAX_VERTICES < EDGE_W) ? MAX_VERTICES : EDGE_W;
  localparam int AW = $clog2(ROW_DEPTH);
  localparam int PW = $clog2(ROW_DEPTH + 1);
  localparam int NW = ($clog2(MAX_VERTICES + 1) > COUNT_W) ? $clog2(MAX_VERTICES + 1)
                                                           : COUNT_W;

  logic [COUNT_W-1:0]  vertex_count;
  logic [VERTEX_W-1:0] start_vertex;

  logic [EDGE_W-1:0]   adj_mem [ROW_DEPTH];
  logic [VERTEX_W-1:0] fifo_mem [ROW_DEPTH];

  logic [VERTEX_W-1:0] node;
  logic [EDGE_W-1:0]   row;
  logic [EDGE_W-1:0]   visited;
  logic [EDGE_W-1:0]   pending;
  logic [PW-1:0]       head;
  logic [PW-1:0]       tail;

  logic [NW-1:0]       n_eff;
  logic [EDGE_W-1:0]   n_mask;
  logic [EDGE_W-1:0]   lowest;
  logic [VERTEX_W-1:0] lowest_idx;
  logic [EDGE_W-1:0]   start_bit;
  logic                fifo_we;
  logic [AW-1:0]       fifo_waddr;
  logic [VERTEX_W-1:0] fifo_wdata;

  // effective vertex count and mask of vertices in use
  always_comb begin
    if (NW'(vertex_count) > NW'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vertex_count);
    end
    for (int j = 0; j < EDGE_W; j++) begin
      n_mask[j] = NW'(j) < n_eff;
    end
  end

  // lowest pending neighbour
  always_comb begin
    lowest = pending & (~pending + EDGE_W'(1));
    lowest_idx = '0;
    for (int j = 0; j < EDGE_W; j++) begin
      if (lowest[j]) begin
        lowest_idx = lowest_idx | VERTEX_W'(j);
      end
    end
    start_bit = EDGE_W'(1) << start_vertex;
  end

  always_comb begin
    fifo_we = cmd.init | cmd.enqueue;
    if (cmd.init) begin
      fifo_waddr = '0;
      fifo_wdata = start_vertex;
    end else begin
      fifo_waddr = tail[AW-1:0];
      fifo_wdata = lowest_idx;
    end
  end

  assign status.bad_start = NW'(start_vertex) >= n_eff;
  assign status.pending_empty = pending == '0;
  assign status.last_result = run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
      start_vertex <= START_VERTEX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT: vertex_count <= cfg_data;
        REG_START_VERTEX: start_vertex <= cfg_data[VERTEX_W-1:0];
        default: ;
      endcase
    end
  end

  // adjacency row memory
  always_ff @(posedge clk) begin
    if (cmd.row_write && (32'(row_index) < ROW_DEPTH)) begin
      adj_mem[row_index[AW-1:0]] <= row_edges;
    end
    if (cmd.read_row) begin
      row <= adj_mem[node[AW-1:0]];
    end
  end

  // vertex fifo memory
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    if (cmd.fetch) begin
      node <= fifo_mem[head[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      pending <= '0;
      head <= '0;
      tail <= '0;
    end else begin
      if (cmd.init) begin
        visited <= start_bit;
        pending <= '0;
        head <= '0;
        tail <= PW'(1);
      end
      if (cmd.fetch) begin
        head <= head + PW'(1);
      end
      if (cmd.scan) begin
        pending <= row & ~visited & n_mask;
      end
      if (cmd.enqueue) begin
        visited <= visited | lowest;
        pending <= pending & ~lowest;
        tail <= tail + PW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_bad) begin
      vertex <= '0;
      run_end <= 1'b1;
      bad_start <= 1'b1;
    end else if (cmd.load_result) begin
      vertex <= node;
      run_end <= head == tail;
      bad_start <= 1'b0;
    end
  end

endmodule

[rtl/bfsam_ctrl.sv]
// controller state machine sequencing row load, traversal and result handshake
// depends on bfsam_pkg

module bfsam_ctrl
  import bfsam_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          last_row,
  output logic          out_valid,
  input  logic          out_ready,
  input  bfsam_status_t status,
  output bfsam_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_ENQ   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_EMIT;
  assign accept = in_valid & in_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.row_write = accept;
        if (accept && last_row) begin
          if (status.bad_start) begin
            cmd.load_bad = 1'b1;
            state_next = S_EMIT;
          end else begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.init = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = S_ROW;
      end
      S_ROW: begin
        cmd.read_row = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        state_next = S_ENQ;
      end
      S_ENQ: begin
        if (status.pending_empty) begin
          cmd.load_result = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.enqueue = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          state_next = status.last_result ? S_IDLE : S_FETCH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/bfs_adjacency_matrix_top.sv]
// Breadth-first search over an adjacency matrix loaded one row per item.
// A row item is written to the row memory when it is taken; rows with
// last_row low give no result. The item with last_row high stores its row
// and then the traversal runs from start_vertex: each visited vertex goes
// through a fifo read, a row memory read, a neighbour scan, one enqueue for
// every newly discovered neighbour and a result load, and then waits on the
// result channel until its item is taken. Neighbours are enqueued one per
// cycle through the single fifo write port, and the reads of the two
// memories are registered. A bad start gives its single result in the
// cycle after the item is taken. No new row is taken until the last
// result of a traversal has been delivered.
// depends on bfsam_pkg, bfsam_if, bfsam_ctrl and bfsam_datapath

module bfs_adjacency_matrix_top
  import bfsam_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  bfsam_row_if.sink              row_in,
  bfsam_result_if.source         result_out
);

  bfsam_cmd_t    cmd;
  bfsam_status_t status;

  bfsam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (row_in.valid),
    .in_ready  (row_in.ready),
    .last_row  (row_in.last_row),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bfsam_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_index (row_in.row_index),
    .row_edges (row_in.row_edges),
    .vertex    (result_out.vertex),
    .run_end   (result_out.run_end),
    .bad_start (result_out.bad_start)
  );

endmodule

[rtl/bfsam_checker.sv]
// port-level checks for the breadth-first search block, bound to the top level
// depends on bfsam_pkg and bfs_adjacency_matrix_top

module bfsam_checker
  import bfsam_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                last_row,
  input logic                out_valid,
  input logic                out_ready,
  input logic [VERTEX_W-1:0] vertex,
  input logic                run_end,
  input logic                bad_start
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vertex) && $stable(run_end)
      && $stable(bad_start))
    else $error("result changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("row taken while a result is pending");

  a_bad_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_start |-> run_end && vertex == '0)
    else $error("bad start result malformed");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && run_end |=> in_ready)
    else $error("not ready after last result");

  a_plain_row: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_row |=> in_ready && !out_valid)
    else $error("plain row started work");

endmodule

bind bfs_adjacency_matrix_top bfsam_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (row_in.valid),
  .in_ready  (row_in.ready),
  .last_row  (row_in.last_row),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .vertex    (result_out.vertex),
  .run_end   (result_out.run_end),
  .bad_start (result_out.bad_start)
);

[tb/bfsam_checker.sv]
// checker for the breadth-first search block: watches the register port and both channels,
// predicts the visit order of each traversal and compares every result item
// depends on bfsam_pkg and bfsam_if

module bfsam_tb_checker
  import bfsam_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  bfsam_row_if                   row,
  bfsam_result_if                res,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 16;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                run_end;
    logic                bad_start;
  } visit_t;

  logic [EDGE_W-1:0]   adj_rows [NV];
  logic [COUNT_W-1:0]  vertex_count;
  logic [VERTEX_W-1:0] start_vertex;
  visit_t              visit_q [$];

  task automatic push_bfs_order();
    int          n;
    int          head;
    int          tail;
    int          node;
    logic [15:0] seen;
    logic [15:0] edges;
    int          order [NV];
    n = (vertex_count > NV) ? NV : int'(vertex_count);
    if (int'(start_vertex) >= n) begin
      visit_q.push_back('{vertex: '0, run_end: 1'b1, bad_start: 1'b1});
      return;
    end
    seen = '0;
    head = 0;
    tail = 0;
    seen[start_vertex] = 1'b1;
    order[tail++] = start_vertex;
    while (head < tail) begin
      node = order[head++];
      edges = adj_rows[node];
      for (int j = 0; j < n; j++) begin
        if (edges[j] && !seen[j] && tail < NV) begin
          seen[j] = 1'b1;
          order[tail++] = j;
        end
      end
      visit_q.push_back('{vertex: node[VERTEX_W-1:0], run_end: head == tail,
                          bad_start: 1'b0});
    end
  endtask

  always @(posedge clk) begin
    visit_t want;
    visit_t got;
    if (rst) begin
      vertex_count = VERTEX_COUNT_RESET;
      start_vertex = START_VERTEX_RESET;
      visit_q.delete();
      for (int i = 0; i < NV; i++) adj_rows[i] = '0;
      mismatches = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_VERTEX_COUNT) vertex_count = cfg_data;
        else if (cfg_index == REG_START_VERTEX) start_vertex = cfg_data[VERTEX_W-1:0];
      end
      if (res.valid && res.ready) begin
        got = '{vertex: res.vertex, run_end: res.run_end, bad_start: res.bad_start};
        if (visit_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t checker: unexpected result item vertex %0d end %0b bad %0b",
                     $realtime, got.vertex, got.run_end, got.bad_start);
          mismatches++;
        end else begin
          want = visit_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t checker: vertex %0d/%0d end %0b/%0b bad %0b/%0b (exp/act)",
                       $realtime, want.vertex, got.vertex, want.run_end, got.run_end,
                       want.bad_start, got.bad_start);
            mismatches++;
          end
        end
      end
      if (row.valid && row.ready) begin
        adj_rows[row.row_index] = row.row_edges;
        if (row.last_row) push_bfs_order();
      end
    end
    outstanding = visit_q.size();
  end

endmodule

[tb/tb_top.sv]
// top of the breadth-first search testbench: clock, reset, row and register stimulus,
// random back-pressure on results, watchdog and verdict
// depends on bfsam_pkg, bfsam_if, bfsam_tb_checker and bfs_adjacency_matrix_top

module tb_top;
  import bfsam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ROWS = 190;
  localparam int QUIET_LIMIT = 2000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     outstanding;
  int                     rows_taken;
  int                     quiet;
  bit                     calm;

  bfsam_row_if    row_bus ();
  bfsam_result_if res_bus ();

  bfs_adjacency_matrix_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .row_in     (row_bus),
    .result_out (res_bus)
  );

  bfsam_tb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .row         (row_bus),
    .res         (res_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) res_bus.ready <= calm || ($urandom_range(99) >= 23);

  always @(posedge clk) begin
    if (rst || (row_bus.valid && row_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [EDGE_W-1:0] rand_edges();
    case ($urandom_range(3))
      0: return EDGE_W'($urandom);
      1: return EDGE_W'($urandom & $urandom);
      2: return EDGE_W'($urandom & $urandom & $urandom);
      default: return EDGE_W'(~($urandom & $urandom));
    endcase
  endfunction

  task automatic send_row(input logic [VERTEX_W-1:0] idx, input logic [EDGE_W-1:0] edges,
                          input logic last);
    while (!calm && $urandom_range(99) < 23) begin
      row_bus.valid <= 1'b0;
      @(negedge clk);
    end
    row_bus.valid     <= 1'b1;
    row_bus.row_index <= idx;
    row_bus.row_edges <= edges;
    row_bus.last_row  <= last;
    @(posedge clk);
    while (!row_bus.ready) @(posedge clk);
    @(negedge clk);
    rows_taken++;
  endtask

  task automatic wait_drained();
    row_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase;
    int vc;
    int eff;
    int sv;
    int n;
    int goal;
    row_bus.valid     = 1'b0;
    row_bus.row_index = '0;
    row_bus.row_edges = '0;
    row_bus.last_row  = 1'b0;
    res_bus.ready     = 1'b0;
    cfg_write         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    rows_taken        = 0;
    quiet             = 0;
    calm              = 1'b0;
    rst               = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill every row, full traversal from vertex 0
    send_row(4'd0, 16'hFFFF, 1'b0);
    for (int r = 1; r < 15; r++) send_row(r[VERTEX_W-1:0], rand_edges(), 1'b0);
    send_row(4'd15, 16'h0000, 1'b1);

    wait_drained();
    set_reg(REG_VERTEX_COUNT, 5'd1);
    send_row(4'd3, 16'hFFFF, 1'b1);

    wait_drained();
    set_reg(REG_VERTEX_COUNT, 5'd31);
    set_reg(REG_START_VERTEX, 5'd15);
    send_row(4'd15, 16'h8001, 1'b1);

    wait_drained();
    set_reg(REG_VERTEX_COUNT, 5'd0);
    send_row(4'd7, rand_edges(), 1'b1);

    wait_drained();
    set_reg(REG_VERTEX_COUNT, 5'd3);
    set_reg(REG_START_VERTEX, 5'd5);
    send_row(4'd2, 16'hFFFF, 1'b1);

    wait_drained();
    set_reg(2'd2, 5'd31);
    set_reg(2'd3, 5'd7);
    set_reg(REG_VERTEX_COUNT, 5'd4);
    set_reg(REG_START_VERTEX, 5'd2);
    send_row(4'd2, 16'hFFFF, 1'b1);

    goal = rows_taken + RANDOM_ROWS;
    phase = 0;
    while (rows_taken < goal) begin
      wait_drained();
      calm = (phase == 4) || (phase == 5);
      case ($urandom_range(19))
        0: vc = 0;
        1: vc = $urandom_range(17, 31);
        2: vc = 16;
        3: vc = 1;
        default: vc = $urandom_range(1, $urandom_range(1, 16));
      endcase
      eff = (vc > 16) ? 16 : vc;
      if (eff == 0 || $urandom_range(9) == 0) sv = $urandom_range(0, 15);
      else sv = $urandom_range(0, eff - 1);
      if ($urandom_range(7) == 0) set_reg(2'($urandom_range(2, 3)), 5'($urandom));
      if ($urandom_range(1)) begin
        set_reg(REG_VERTEX_COUNT, 5'(vc));
        set_reg(REG_START_VERTEX, {1'($urandom), 4'(sv)});
      end else begin
        set_reg(REG_START_VERTEX, {1'($urandom), 4'(sv)});
        set_reg(REG_VERTEX_COUNT, 5'(vc));
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(4) != 0) begin
          n = (eff == 0) ? $urandom_range(1, 4) : eff;
          for (int r = 0; r < n; r++)
            send_row(r[VERTEX_W-1:0], rand_edges(), r == n - 1);
        end else begin
          repeat ($urandom_range(1, 3))
            send_row(4'($urandom), rand_edges(), $urandom_range(9) < 3);
        end
      end
      phase++;
    end
    calm = 1'b0;

    wait_drained();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
